// ===== hdl/iaalu_pkg.sv =====
package iaalu_pkg;

	// Internal arithmetic width; operand and result fields stay at 32 bits.
	localparam int WORD_W  = 32;
	localparam int SHAMT_W = $clog2(WORD_W);
	localparam int FIELD_W = 32;
	localparam int CFG_W   = 16;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [4:0] {
		OP_ADD      = 5'd0,
		OP_SUB      = 5'd1,
		OP_MUL      = 5'd2,
		OP_DIV      = 5'd3,
		OP_MOD      = 5'd4,
		OP_NEG      = 5'd5,
		OP_SHL      = 5'd6,
		OP_SHR      = 5'd7,
		OP_AND      = 5'd8,
		OP_OR       = 5'd9,
		OP_NOT      = 5'd10,
		OP_LAND     = 5'd11,
		OP_LOR      = 5'd12,
		OP_LNOT     = 5'd13,
		OP_MAXINT   = 5'd14,
		OP_MININT   = 5'd15,
		OP_MAXARITY = 5'd16,
		OP_MAXDEPTH = 5'd17
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DIVZERO = 2'd1,
		ST_UNDEF   = 2'd2,
		ST_NOTCOMP = 2'd3
	} status_t;

	typedef enum logic {
		CFG_MAX_ARITY = 1'b0,
		CFG_MAX_DEPTH = 1'b1
	} cfg_index_t;

	// Side information that rides along the divider pipe
	typedef struct packed {
		word_t   early;   // result of every non-divide opcode
		logic    use_div; // take the divider output
		logic    is_mod;  // remainder rather than quotient
		logic    neg;     // negate divider magnitude
		status_t status;
	} side_t;

	// Restoring divider state
	typedef struct packed {
		word_t rem;
		word_t dvd;       // dividend bits in, quotient bits out
		word_t dsr;
	} div_t;

	// Sign-extend a 32-bit field, then cut to the word width
	function automatic word_t to_word(logic [FIELD_W-1:0] v);
		logic [63:0] x;
		x = 64'(signed'(v));
		return x[WORD_W-1:0];
	endfunction

	// Sign-extend a word, then cut to the 32-bit field
	function automatic logic [FIELD_W-1:0] to_field(word_t w);
		logic [63:0] x;
		x = 64'(signed'(w));
		return x[FIELD_W-1:0];
	endfunction

	// Zero-extend a register value, then cut to the word width
	function automatic word_t cfg_word(logic [CFG_W-1:0] v);
		logic [63:0] x;
		x = 64'(v);
		return x[WORD_W-1:0];
	endfunction

endpackage

// ===== hdl/integer_expression_alu.sv =====
// Signed integer ALU, one operation per transaction.
// Input stream (s_*): tdata carries operand_a [31:0] and operand_b [63:32];
// tuser carries mode [4:0] and strict [5]. Output stream (m_*): tdata
// carries result_value [31:0], tuser carries status [1:0].
// Configuration: cfg_we with cfg_addr 0 (max arity) or 1 (max depth) and
// 16-bit cfg_wdata; write only while the pipe is empty.
// Throughput: one transaction per cycle while not stalled. Path: the
// result leaves on m_* after passing an input register, one decode
// and multiply stage, one stage per quotient bit of the restoring divider
// (WORD_W stages) and the output register. Every opcode takes the same
// path, so results come out in order.
// Stall: the whole pipe advances only while the output register is empty
// or being taken, so s_tready follows m_tready combinationally; nothing
// is dropped or repeated while held.
// Reset (arst_n low): all valid bits clear, the pipe empties, the limits
// return to 255 and 1000.
module integer_expression_alu
	import iaalu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,   // operand_a [31:0], operand_b [63:32]
	input  logic [5:0]         s_tuser,   // mode [4:0], strict [5]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [FIELD_W-1:0] m_tdata,   // result_value [31:0]
	output logic [1:0]         m_tuser,   // status [1:0]
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	logic             en;
	logic [CFG_W-1:0] max_arity_q;
	logic [CFG_W-1:0] max_depth_q;

	logic             valid_s1;
	logic [4:0]       mode_s1;
	word_t            a_s1;
	word_t            b_s1;
	logic             strict_s1;

	// index 0 is the front stage output, index WORD_W the last divider step
	logic             valid_d [WORD_W+1];
	side_t            side_d  [WORD_W+1];
	div_t             div_d   [WORD_W+1];

	// global advance: output slot free or being emptied
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_arity_q <= CFG_W'(255);
			max_depth_q <= CFG_W'(1000);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_addr))
				CFG_MAX_ARITY: max_arity_q <= cfg_wdata;
				CFG_MAX_DEPTH: max_depth_q <= cfg_wdata;
				default:       max_arity_q <= max_arity_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= s_tuser[4:0];
			strict_s1 <= s_tuser[5];
			a_s1      <= to_word(s_tdata[31:0]);
			b_s1      <= to_word(s_tdata[63:32]);
		end
	end

	// decode, simple ops, multiply, operand magnitudes
	iaalu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_s1    (valid_s1),
		.mode_s1     (mode_s1),
		.a_s1        (a_s1),
		.b_s1        (b_s1),
		.strict_s1   (strict_s1),
		.max_arity_q (max_arity_q),
		.max_depth_q (max_depth_q),
		.valid_s2    (valid_d[0]),
		.side_s2     (side_d[0]),
		.div_s2      (div_d[0])
	);

	// one quotient bit per stage
	for (genvar i = 0; i < WORD_W; i++) begin : g_div
		iaalu_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid_d[i]),
			.side_in  (side_d[i]),
			.div_in   (div_d[i]),
			.valid_q  (valid_d[i+1]),
			.side_q   (side_d[i+1]),
			.div_q    (div_d[i+1])
		);
	end

	// sign fix-up, result select, output register
	iaalu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (valid_d[WORD_W]),
		.side_in  (side_d[WORD_W]),
		.div_in   (div_d[WORD_W]),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== hdl/iaalu_front.sv =====
module iaalu_front
	import iaalu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s1,
	input  logic [4:0]           mode_s1,
	input  word_t                a_s1,
	input  word_t                b_s1,
	input  logic                 strict_s1,
	input  logic [CFG_W-1:0]     max_arity_q,
	input  logic [CFG_W-1:0]     max_depth_q,
	output logic                 valid_s2,
	output side_t                side_s2,
	output div_t                 div_s2
);

	side_t side_d;
	div_t  div_d;
	logic  shamt_ok;
	logic  a_neg;
	logic  b_neg;

	assign a_neg    = a_s1[WORD_W-1];
	assign b_neg    = b_s1[WORD_W-1];
	// negative amounts have the top bit set and so compare large
	assign shamt_ok = (b_s1 < word_t'(WORD_W));

	always_comb begin
		side_d         = '0;
		side_d.status  = ST_OK;
		div_d.rem      = '0;
		div_d.dvd      = a_neg ? word_t'(-a_s1) : a_s1;
		div_d.dsr      = b_neg ? word_t'(-b_s1) : b_s1;
		unique case (opcode_t'(mode_s1)) inside
			OP_ADD:      side_d.early = a_s1 + b_s1;
			OP_SUB:      side_d.early = a_s1 - b_s1;
			OP_MUL:      side_d.early = word_t'(a_s1 * b_s1);
			OP_DIV, OP_MOD: begin
				side_d.use_div = 1'b1;
				side_d.is_mod  = (opcode_t'(mode_s1) == OP_MOD);
				side_d.neg     = (opcode_t'(mode_s1) == OP_MOD) ? a_neg : (a_neg ^ b_neg);
				if (b_s1 == '0) begin
					side_d.status = ST_DIVZERO;
				end
			end
			OP_NEG:      side_d.early = word_t'(-a_s1);
			OP_SHL:      side_d.early = shamt_ok ? (a_s1 << b_s1[SHAMT_W-1:0]) : '0;
			OP_SHR:      side_d.early = shamt_ok ?
				word_t'($signed(a_s1) >>> b_s1[SHAMT_W-1:0]) : {WORD_W{a_neg}};
			OP_AND:      side_d.early = a_s1 & b_s1;
			OP_OR:       side_d.early = a_s1 | b_s1;
			OP_NOT:      side_d.early = ~a_s1;
			OP_LAND:     side_d.early = word_t'((a_s1 != '0) && (b_s1 != '0));
			OP_LOR:      side_d.early = word_t'((a_s1 != '0) || (b_s1 != '0));
			OP_LNOT:     side_d.early = word_t'(a_s1 == '0);
			OP_MAXINT:   side_d.early = {1'b0, {(WORD_W-1){1'b1}}};
			OP_MININT:   side_d.early = {1'b1, {(WORD_W-1){1'b0}}};
			OP_MAXARITY: side_d.early = cfg_word(max_arity_q);
			OP_MAXDEPTH: side_d.early = cfg_word(max_depth_q);
			default:     side_d.status = strict_s1 ? ST_UNDEF : ST_NOTCOMP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_d;
			div_s2  <= div_d;
		end
	end

endmodule

// ===== hdl/iaalu_div_step.sv =====
module iaalu_div_step
	import iaalu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  side_t side_in,
	input  div_t  div_in,
	output logic  valid_q,
	output side_t side_q,
	output div_t  div_q
);

	word_t trial;
	logic  take;
	div_t  div_d;

	// remainder stays below the divisor, so the shifted value fits a word
	assign trial = {div_in.rem[WORD_W-2:0], div_in.dvd[WORD_W-1]};
	assign take  = (trial >= div_in.dsr);

	always_comb begin
		div_d.dsr = div_in.dsr;
		div_d.rem = take ? (trial - div_in.dsr) : trial;
		div_d.dvd = {div_in.dvd[WORD_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			div_q  <= div_d;
		end
	end

endmodule

// ===== hdl/iaalu_back.sv =====
module iaalu_back
	import iaalu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  side_t              side_in,
	input  div_t               div_in,
	output logic               m_tvalid,
	output logic [FIELD_W-1:0] m_tdata,
	output logic [1:0]         m_tuser
);

	word_t mag;
	word_t res;

	always_comb begin
		mag = side_in.is_mod ? div_in.rem : div_in.dvd;
		if (side_in.status != ST_OK) begin
			res = '0;
		end else if (side_in.use_div) begin
			res = side_in.neg ? word_t'(-mag) : mag;
		end else begin
			res = side_in.early;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= to_field(res);
			m_tuser <= side_in.status;
		end
	end

endmodule

// ===== bench/integer_expression_alu_test.sv =====
`timescale 1ns / 1ps

// Bench for the signed integer ALU.
// Operations go in on the s_* stream, results come back on m_* in order.
// A scoreboard predicts every result from the operation and the limit
// registers, and checks each returned transaction field by field against
// the oldest prediction still outstanding.
module integer_expression_alu_test;
	import iaalu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;  // watchdog
	localparam int IDLE_PCT    = 19;      // chance in a hundred of a gap or a stall
	localparam int HOLD_CYCLES = 300;     // long receiver hold-off, well past pipe depth
	localparam int TAIL_CYCLES = 40;      // idle tail before the final check

	// opcodes the block does not know
	localparam logic [4:0] OP_UNUSED_LO = 5'd18;
	localparam logic [4:0] OP_UNUSED_HI = 5'd31;

	localparam logic [31:0] FIELD_MIN = 32'h8000_0000;
	localparam logic [31:0] FIELD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

	typedef struct {
		logic [4:0]  mode;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] value;
		status_t     status;
	} alu_outcome_t;

	// Predicts ALU results and compares them with what comes out
	class alu_scoreboard;
		logic [CFG_W-1:0] arity_limit;
		logic [CFG_W-1:0] depth_limit;
		alu_outcome_t     outstanding[$];
		int               noted;
		int               compared;
		int               faults;

		function new();
			arity_limit = 16'd255;
			depth_limit = 16'd1000;
		endfunction

		function void set_limit(cfg_index_t idx, logic [CFG_W-1:0] value);
			if (idx == CFG_MAX_ARITY)
				arity_limit = value;
			else
				depth_limit = value;
		endfunction

		// cut to the internal word width and sign-extend back to 64 bits
		function longint to_width(longint v);
			return (v <<< (64 - WORD_W)) >>> (64 - WORD_W);
		endfunction

		function alu_outcome_t evaluate(logic [4:0] mode, logic [31:0] a_f, logic [31:0] b_f,
				logic strict);
			longint       a;
			longint       b;
			longint       r;
			status_t      st;
			alu_outcome_t res;
			a  = to_width(longint'(signed'(a_f)));
			b  = to_width(longint'(signed'(b_f)));
			r  = 0;
			st = ST_OK;
			case (opcode_t'(mode)) inside
				OP_ADD:  r = a + b;
				OP_SUB:  r = a - b;
				OP_MUL:  r = a * b;
				OP_DIV, OP_MOD: begin
					// minimum over minus one wraps; keep it out of native division
					if (b == 0)
						st = ST_DIVZERO;
					else if (b == -1)
						r = (mode == OP_DIV) ? -a : 0;
					else
						r = (mode == OP_DIV) ? a / b : a % b;
				end
				OP_NEG:  r = -a;
				OP_SHL:  r = (b < 0 || b >= WORD_W) ? 0 : a << b;
				OP_SHR: begin
					// out-of-range shift leaves only the sign fill
					if (b < 0 || b >= WORD_W)
						r = (a < 0) ? -1 : 0;
					else
						r = a >>> b;
				end
				OP_AND:      r = a & b;
				OP_OR:       r = a | b;
				OP_NOT:      r = ~a;
				OP_LAND:     r = (a != 0 && b != 0) ? 1 : 0;
				OP_LOR:      r = (a != 0 || b != 0) ? 1 : 0;
				OP_LNOT:     r = (a == 0) ? 1 : 0;
				OP_MAXINT:   r = (longint'(1) << (WORD_W - 1)) - 1;
				OP_MININT:   r = longint'(1) << (WORD_W - 1);
				OP_MAXARITY: r = longint'(arity_limit);
				OP_MAXDEPTH: r = longint'(depth_limit);
				default:     st = strict ? ST_UNDEF : ST_NOTCOMP;
			endcase
			if (st != ST_OK)
				r = 0;
			r          = to_width(r);
			res.mode   = mode;
			res.a      = a_f;
			res.b      = b_f;
			res.value  = r[31:0];
			res.status = st;
			return res;
		endfunction

		function void flag(string what);
			faults++;
			if (faults <= 10)
				$display("[%0t] %s", $time, what);
		endfunction

		function void note_operation(logic [4:0] mode, logic [31:0] a, logic [31:0] b,
				logic strict);
			outstanding.push_back(evaluate(mode, a, b, strict));
			noted++;
		endfunction

		function void check_result(logic [31:0] value, logic [1:0] status);
			alu_outcome_t e;
			compared++;
			if (outstanding.size() == 0) begin
				flag($sformatf("result %h status %0d with nothing outstanding", value, status));
				return;
			end
			e = outstanding.pop_front();
			if (value !== e.value || status !== e.status)
				flag($sformatf("op %0d a=%h b=%h: want value %h status %0d, got %h status %0d",
					e.mode, e.a, e.b, e.value, e.status, value, status));
		endfunction

		function int pending();
			return outstanding.size();
		endfunction

		function void close();
			if (outstanding.size() != 0)
				flag($sformatf("%0d results never arrived", outstanding.size()));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [63:0]       s_tdata;   // operand_a [31:0], operand_b [63:32]
	logic [5:0]        s_tuser;   // mode [4:0], strict [5]
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;   // result_value [31:0]
	logic [1:0]        m_tuser;   // status [1:0]
	logic              cfg_we;
	logic              cfg_addr;
	logic [CFG_W-1:0]  cfg_wdata;

	alu_scoreboard board;
	bit            tx_steady;     // sender never leaves a gap
	bit            rx_steady;     // receiver never stalls
	bit            hold_request;  // asks the receiver for one long hold-off
	int            cycle_count;
	int            settings_used;

	integer_expression_alu dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Offer one operation, with random gaps first, and wait for the transaction.
	// Handshake signals are sampled at the edge, before this edge's updates land.
	task automatic send_op(logic [4:0] mode, logic [31:0] a, logic [31:0] b, logic strict);
		if (!tx_steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tuser  <= {strict, mode};
		do begin
			@(posedge clk);
		end while (!s_tready);
		board.note_operation(mode, a, b, strict);
	endtask

	// Mostly corner values and small numbers, otherwise anything
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 32'd1;
			2:       return ALL_ONES;
			3:       return FIELD_MIN;
			4:       return FIELD_MAX;
			5, 6:    return 32'($urandom_range(64)) - 32'd32;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random_ops(int count);
		logic [4:0]  mode;
		logic [31:0] a;
		logic [31:0] b;
		repeat (count) begin
			if ($urandom_range(9) == 0)
				mode = 5'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
			else
				mode = 5'($urandom_range(OP_MAXDEPTH, OP_ADD));
			a = pick_operand();
			b = pick_operand();
			// keep most shifts in range so the shifter itself gets exercised
			if ((mode == OP_SHL || mode == OP_SHR) && $urandom_range(3) != 0)
				b = 32'($urandom_range(WORD_W - 1));
			if ((mode == OP_DIV || mode == OP_MOD) && $urandom_range(7) == 0)
				b = '0;
			send_op(mode, a, b, 1'($urandom_range(1)));
		end
	endtask

	// Drop valid and wait for every outstanding result; the pipe is then empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Both limit registers, on consecutive edges; only with the pipe empty
	task automatic program_limits(logic [CFG_W-1:0] arity, logic [CFG_W-1:0] depth);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MAX_ARITY;
		cfg_wdata <= arity;
		@(posedge clk);
		board.set_limit(CFG_MAX_ARITY, arity);
		cfg_addr  <= CFG_MAX_DEPTH;
		cfg_wdata <= depth;
		@(posedge clk);
		board.set_limit(CFG_MAX_DEPTH, depth);
		cfg_we    <= 1'b0;
		settings_used++;
	endtask

	// Takes results, checks them, and decides m_tready for the next cycle
	task automatic run_receiver();
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tuser);
			if (hold_request) begin
				hold_request = 1'b0;
				held         = HOLD_CYCLES;
			end
			if (held > 0) begin
				held--;
				m_tready <= 1'b0;
			end else if (rx_steady)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
		end
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("watchdog expired after %0d cycles", cycle_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		m_tready      = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = CFG_MAX_ARITY;
		cfg_wdata     = '0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		hold_request  = 1'b0;
		settings_used = 1;
		board         = new();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			run_receiver();
		join_none

		// Directed: every opcode at least once, plus the corners, with the reset limits
		send_op(OP_ADD, FIELD_MAX, 32'd1, 1'b0);             // wraps to minimum
		send_op(OP_SUB, FIELD_MIN, 32'd1, 1'b0);             // wraps to maximum
		send_op(OP_MUL, FIELD_MAX, FIELD_MAX, 1'b1);         // product wraps
		send_op(OP_DIV, 32'd7, -32'sd2, 1'b0);               // truncates toward zero
		send_op(OP_MOD, -32'sd7, 32'd2, 1'b0);               // sign of dividend
		send_op(OP_DIV, 32'd5, '0, 1'b0);                    // divide by zero
		send_op(OP_MOD, FIELD_MIN, '0, 1'b1);                // remainder by zero
		send_op(OP_DIV, FIELD_MIN, ALL_ONES, 1'b0);          // minimum over minus one
		send_op(OP_MOD, FIELD_MIN, ALL_ONES, 1'b0);
		send_op(OP_NEG, FIELD_MIN, '0, 1'b0);
		send_op(OP_SHL, 32'd1, 32'd31, 1'b0);
		send_op(OP_SHL, ALL_ONES, 32'd32, 1'b0);             // shift past the word
		send_op(OP_SHR, -32'sd8, 32'd1, 1'b0);
		send_op(OP_SHR, FIELD_MIN, 32'd40, 1'b0);            // sign fill only
		send_op(OP_AND, 32'hf0f0_f0f0, 32'h3c3c_3c3c, 1'b0);
		send_op(OP_OR, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 1'b0);
		send_op(OP_NOT, '0, ALL_ONES, 1'b0);
		send_op(OP_LAND, 32'd5, '0, 1'b0);
		send_op(OP_LOR, '0, FIELD_MIN, 1'b0);
		send_op(OP_LNOT, '0, 32'd9, 1'b0);
		send_op(OP_MAXINT, ALL_ONES, ALL_ONES, 1'b0);
		send_op(OP_MININT, '0, '0, 1'b1);
		send_op(OP_MAXARITY, $urandom(), $urandom(), 1'b0);
		send_op(OP_MAXDEPTH, $urandom(), $urandom(), 1'b1);
		send_op(OP_UNUSED_LO, FIELD_MAX, FIELD_MAX, 1'b1);   // unknown, strict
		send_op(OP_UNUSED_HI, FIELD_MAX, FIELD_MAX, 1'b0);   // unknown, lenient
		drain();

		// Limits at opposite extremes, random gaps on both sides
		program_limits('0, '1);
		send_random_ops(106);
		drain();

		// Extremes swapped; a long stretch with no gaps and no stalls at all
		program_limits('1, '0);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_random_ops(106);
		drain();
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		// Random limits; the receiver holds off long enough for the pipe to
		// fill and push back on the sender
		program_limits(16'($urandom()), 16'($urandom()));
		hold_request = 1'b1;
		send_random_ops(110);
		drain();

		program_limits(16'($urandom()), 16'($urandom()));
		send_random_ops(106);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		board.close();
		$display("%0d operations (26 directed) across %0d limit settings, with gaps, stalls,",
			board.noted, settings_used);
		$display("one %0d-cycle output hold-off; %0d results compared, %0d faults",
			HOLD_CYCLES, board.compared, board.faults);
		if (board.faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
